[sv/igm_pkg.sv]
// Shared types and constants for the bordered image gradient magnitude block.
// Used by the controller, the datapath and the top level; depends on nothing.
package igm_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_NEXT,
    ST_WRITE,
    ST_PICK,
    ST_MUL,
    ST_SUM,
    ST_SQRT,
    ST_OUT
  } state_t;

  // Configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Result slots one pixel can cause, in emission order
  localparam logic [1:0] RES_ABOVE  = 2'd0;  // pixel one row up, same column
  localparam logic [1:0] RES_LEFT   = 2'd1;  // last row, column to the left
  localparam logic [1:0] RES_CORNER = 2'd2;  // last row, last column

  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;

  typedef struct packed {
    logic       accept;     // capture pixel, read both stores at column
    logic       read_next;  // read newer store at column + 1
    logic       write;      // capture right neighbor, update both stores
    logic       load;       // form differences for slot sel
    logic [1:0] sel;
    logic       mul;
    logic       sum;
    logic       sqrt_step;
    logic       advance;    // shift pixel history, step position
  } cmd_t;

  typedef struct packed {
    logic [2:0] en;         // which result slots this pixel emits
    logic       sqrt_done;
  } status_t;

endpackage

[sv/igm_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module igm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[sv/igm_ctrl.sv]
// Sequencer for the gradient block: steps each pixel through store access,
// result formation, square root and output handshake. Uses igm_pkg.
module igm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              pixel_valid,
  output logic              pixel_stall,
  output logic              result_valid,
  input  logic              result_stall,
  input  igm_pkg::status_t  status,
  output igm_pkg::cmd_t     cmd
);

  igm_pkg::state_t state, state_next;
  logic [1:0] slot, slot_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= igm_pkg::ST_IDLE;
      slot  <= igm_pkg::RES_ABOVE;
    end else begin
      state <= state_next;
      slot  <= slot_next;
    end
  end

  always_comb begin
    state_next   = state;
    slot_next    = slot;
    cmd          = '0;
    cmd.sel      = slot;
    pixel_stall  = 1'b1;
    result_valid = 1'b0;
    case (state)
      igm_pkg::ST_IDLE: begin
        pixel_stall = 1'b0;
        if (pixel_valid) begin
          cmd.accept = 1'b1;
          state_next = igm_pkg::ST_RD_NEXT;
        end
      end
      igm_pkg::ST_RD_NEXT: begin
        cmd.read_next = 1'b1;
        state_next    = igm_pkg::ST_WRITE;
      end
      igm_pkg::ST_WRITE: begin
        cmd.write  = 1'b1;
        slot_next  = igm_pkg::RES_ABOVE;
        state_next = igm_pkg::ST_PICK;
      end
      igm_pkg::ST_PICK: begin
        if (status.en[slot]) begin
          cmd.load   = 1'b1;
          state_next = igm_pkg::ST_MUL;
        end else if (slot == igm_pkg::RES_CORNER) begin
          cmd.advance = 1'b1;
          state_next  = igm_pkg::ST_IDLE;
        end else begin
          slot_next = slot + 2'd1;
        end
      end
      igm_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = igm_pkg::ST_SUM;
      end
      igm_pkg::ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = igm_pkg::ST_SQRT;
      end
      igm_pkg::ST_SQRT: begin
        if (status.sqrt_done) begin
          state_next = igm_pkg::ST_OUT;
        end else begin
          cmd.sqrt_step = 1'b1;
        end
      end
      igm_pkg::ST_OUT: begin
        result_valid = 1'b1;
        if (!result_stall) begin
          if (slot == igm_pkg::RES_CORNER) begin
            cmd.advance = 1'b1;
            state_next  = igm_pkg::ST_IDLE;
          end else begin
            slot_next  = slot + 2'd1;
            state_next = igm_pkg::ST_PICK;
          end
        end
      end
      default: begin
        state_next = igm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[sv/igm_datapath.sv]
// Datapath: configuration, position counters, two row stores, pixel history,
// difference selection, squaring and a bit-pair square root. Uses igm_pkg, igm_ram.
module igm_datapath #(
  parameter int MAX_WIDTH  = 2048,
  parameter int PIXEL_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [15:0]         pixel,
  input  igm_pkg::cmd_t       cmd,
  output igm_pkg::status_t    status,
  output logic signed [17:0]  grad_x,
  output logic signed [17:0]  grad_y,
  output logic [17:0]         magnitude,
  output logic [10:0]         out_column,
  output logic [15:0]         out_row,
  output logic                last_of_run,
  output logic                frame_end
);

  localparam int PB = PIXEL_BITS;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int DW = PB + 2;          // signed difference
  localparam int AW = PB + 1;          // magnitude of a difference
  localparam int SW = PB + 2;          // square root result bits
  localparam int NW = 2 * SW;          // radicand bits
  localparam int KW = $clog2(SW + 1);
  localparam logic [WW-1:0] WMAX = WW'(MAX_WIDTH);

  // Configuration and position
  logic [11:0]   cfg_width;
  logic [15:0]   cfg_height;
  logic [CW-1:0] col;
  logic [15:0]   row;
  logic [WW-1:0] w_eff, w_last;
  logic [15:0]   h_eff, h_last;
  logic          at_right, at_bottom;
  logic [WW+11:0] cfg_width_x;

  assign cfg_width_x = {{WW{1'b0}}, cfg_width};

  always_comb begin
    if (cfg_width < 12'd2) begin
      w_eff = WW'(2);
    end else if (cfg_width_x > {12'b0, WMAX}) begin
      w_eff = WMAX;
    end else begin
      w_eff = cfg_width_x[WW-1:0];
    end
    h_eff  = (cfg_height < 16'd2) ? 16'd2 : cfg_height;
    w_last = w_eff - WW'(1);
    h_last = h_eff - 16'd1;
  end

  assign at_right  = ({{(WW + 1 - CW){1'b0}}, col} == {1'b0, w_last});
  assign at_bottom = (row == h_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= igm_pkg::WIDTH_RESET;
      cfg_height <= igm_pkg::HEIGHT_RESET;
      col        <= '0;
      row        <= '0;
    end else if (cfg_write_en) begin
      // any write restarts the frame
      if (cfg_index == igm_pkg::REG_WIDTH) begin
        cfg_width <= cfg_data[11:0];
      end else begin
        cfg_height <= cfg_data;
      end
      col <= '0;
      row <= '0;
    end else if (cmd.advance) begin
      if (at_right) begin
        col <= '0;
        row <= at_bottom ? 16'd0 : row + 16'd1;
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // Row stores
  logic [PB+15:0] pixel_x;
  logic [PB-1:0]  p, a, b, right, prev, prev2, prev_b;
  logic [PB-1:0]  older_rdata, newer_rdata;
  logic [CW-1:0]  newer_addr;

  assign pixel_x    = {{PB{1'b0}}, pixel};
  assign newer_addr = cmd.read_next ? col + CW'(1) : col;

  igm_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_older (
    .clk   (clk),
    .we    (cmd.write),
    .addr  (col),
    .wdata (b),
    .rdata (older_rdata)
  );

  igm_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_newer (
    .clk   (clk),
    .we    (cmd.write),
    .addr  (newer_addr),
    .wdata (p),
    .rdata (newer_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prev   <= '0;
      prev2  <= '0;
      prev_b <= '0;
    end else if (cmd.advance) begin
      prev   <= p;
      prev2  <= prev;
      prev_b <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      p <= pixel_x[PB-1:0];
    end
    if (cmd.read_next) begin
      a <= older_rdata;
      b <= newer_rdata;
    end
    if (cmd.write) begin
      right <= newer_rdata;
    end
  end

  // Which results this pixel emits
  assign status.en[igm_pkg::RES_ABOVE]  = (row != 16'd0);
  assign status.en[igm_pkg::RES_LEFT]   = at_bottom && (col != '0);
  assign status.en[igm_pkg::RES_CORNER] = at_bottom && at_right;

  // Difference selection
  function automatic logic signed [DW-1:0] diff(input logic [PB-1:0] x,
                                               input logic [PB-1:0] y,
                                               input logic dbl);
    logic signed [DW-1:0] d;
    d = $signed({2'b00, x}) - $signed({2'b00, y});
    return dbl ? d <<< 1 : d;
  endfunction

  logic signed [DW-1:0] gx_sel, gy_sel, gx, gy;
  logic [CW-1:0]        col_sel, col_o;
  logic [15:0]          row_sel;
  logic                 last_sel;

  always_comb begin
    case (cmd.sel)
      igm_pkg::RES_ABOVE: begin
        if (col == '0) begin
          gx_sel = diff(right, b, 1'b1);
        end else if (at_right) begin
          gx_sel = diff(b, prev_b, 1'b1);
        end else begin
          gx_sel = diff(right, prev_b, 1'b0);
        end
        gy_sel   = (row == 16'd1) ? diff(b, p, 1'b1) : diff(a, p, 1'b0);
        col_sel  = col;
        row_sel  = row - 16'd1;
        last_sel = !status.en[igm_pkg::RES_LEFT] && !status.en[igm_pkg::RES_CORNER];
      end
      igm_pkg::RES_LEFT: begin
        gx_sel   = (col == CW'(1)) ? diff(p, prev, 1'b1) : diff(p, prev2, 1'b0);
        gy_sel   = diff(prev_b, prev, 1'b1);
        col_sel  = col - CW'(1);
        row_sel  = row;
        last_sel = !status.en[igm_pkg::RES_CORNER];
      end
      default: begin
        gx_sel   = diff(p, prev, 1'b1);
        gy_sel   = diff(b, p, 1'b1);
        col_sel  = col;
        row_sel  = row;
        last_sel = 1'b1;
      end
    endcase
  end

  logic [CW+10:0] col_x;
  assign col_x = {11'b0, col_o};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gx          <= gx_sel;
      gy          <= gy_sel;
      col_o       <= col_sel;
      out_row     <= row_sel;
      last_of_run <= last_sel;
      frame_end   <= (cmd.sel == igm_pkg::RES_CORNER);
    end
  end

  // Squares and radicand
  logic [AW-1:0]   ax, ay;
  logic [2*AW-1:0] sqx, sqy;
  logic [NW-1:0]   rad, res, bitv, trial;
  logic [KW-1:0]   steps;
  logic [DW-1:0]   gx_u, gy_u;

  assign gx_u = gx[DW-1] ? DW'(-gx) : DW'(gx);
  assign gy_u = gy[DW-1] ? DW'(-gy) : DW'(gy);
  assign ax   = gx_u[AW-1:0];
  assign ay   = gy_u[AW-1:0];
  assign trial = res + bitv;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      sqx <= ax * ax;
      sqy <= ay * ay;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (cmd.sum) begin
      steps <= KW'(SW);
    end else if (cmd.sqrt_step && steps != '0) begin
      steps <= steps - KW'(1);
    end
  end

  // one radicand bit pair per cycle
  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      rad  <= NW'(sqx) + NW'(sqy);
      res  <= '0;
      bitv <= NW'(1) << (NW - 2);
    end else if (cmd.sqrt_step && steps != '0) begin
      if (rad >= trial) begin
        rad <= rad - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  assign status.sqrt_done = (steps == '0);

  // sign-extend or mask to the result field widths
  assign grad_x     = 18'(gx);
  assign grad_y     = 18'(gy);
  assign magnitude  = 18'(res);
  assign out_column = col_x[10:0];

endmodule

[sv/image_gradient_magnitude_bordered_core.sv]
// Top level of the bordered central-difference gradient magnitude block.
// Joins igm_ctrl and igm_datapath; uses igm_pkg.
//
//  channel   signals                                       direction
//  pixel     pixel_valid, pixel_stall, pixel               in
//  result    result_valid, result_stall, grad_x, grad_y,   out
//            magnitude, out_column, out_row, last_of_run, frame_end
//  config    cfg_write_en, cfg_index, cfg_data             in
//
// A pixel that emits nothing passes IDLE, RD_NEXT, WRITE and PICK; each result adds MUL,
// SUM, SQRT and OUT plus its output stall, the square root taking one bit pair a cycle.
// Single-port row stores: newer read twice, older once, each written once per pixel.
// Reset (rst, synchronous) restores 640 x 480 and position zero; row stores
// are not cleared. A stalled result holds its fields; no pixel is taken meanwhile.
module image_gradient_magnitude_bordered_core #(
  parameter int MAX_WIDTH  = 2048,
  parameter int PIXEL_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               pixel_valid,
  output logic               pixel_stall,
  input  logic [15:0]        pixel,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [17:0] grad_x,
  output logic signed [17:0] grad_y,
  output logic [17:0]        magnitude,
  output logic [10:0]        out_column,
  output logic [15:0]        out_row,
  output logic               last_of_run,
  output logic               frame_end
);

  igm_pkg::cmd_t    cmd;
  igm_pkg::status_t status;

  igm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  igm_datapath #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel        (pixel),
    .cmd          (cmd),
    .status       (status),
    .grad_x       (grad_x),
    .grad_y       (grad_y),
    .magnitude    (magnitude),
    .out_column   (out_column),
    .out_row      (out_row),
    .last_of_run  (last_of_run),
    .frame_end    (frame_end)
  );

endmodule

[sv/igm_checker.sv]
// Port-level checks for the gradient block, bound to the top level.
// Depends on image_gradient_magnitude_bordered_core.
module igm_checker (
  input logic               clk,
  input logic               rst,
  input logic               pixel_valid,
  input logic               pixel_stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic signed [17:0] grad_x,
  input logic signed [17:0] grad_y,
  input logic [17:0]        magnitude,
  input logic               last_of_run,
  input logic               frame_end
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result request dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(magnitude) && $stable(grad_x) && $stable(grad_y))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_stall |=> pixel_stall)
    else $error("pixel taken back to back");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_end |-> last_of_run)
    else $error("frame end not last of run");

  a_no_take_while_out: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pixel_stall)
    else $error("pixel taken while result pending");

endmodule

bind image_gradient_magnitude_bordered_core igm_checker u_igm_checker (.*);
